// ----- design/nirfd_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and window helpers for the nec ir frame decoder
// no dependencies; used by every module of the decoder

package nirfd_pkg;

  // configuration register map, index = paddr[4:2]
  localparam int unsigned RegAddrW = 5;
  localparam logic [2:0] REG_HDR_MARK   = 3'd0;
  localparam logic [2:0] REG_HDR_SPACE  = 3'd1;
  localparam logic [2:0] REG_BIT_MARK   = 3'd2;
  localparam logic [2:0] REG_ZERO_SPACE = 3'd3;
  localparam logic [2:0] REG_ONE_SPACE  = 3'd4;
  localparam logic [2:0] REG_TOLERANCE  = 3'd5;
  localparam logic [2:0] REG_EXTENDED   = 3'd6;

  // register reset values
  localparam logic [15:0] RstHdrMark   = 16'd9000;
  localparam logic [15:0] RstHdrSpace  = 16'd4500;
  localparam logic [15:0] RstBitMark   = 16'd560;
  localparam logic [15:0] RstZeroSpace = 16'd560;
  localparam logic [15:0] RstOneSpace  = 16'd1690;
  localparam logic [7:0]  RstTolerance = 8'd64;
  localparam logic        RstExtended  = 1'b0;

  // index of the final data bit of a frame
  localparam logic [4:0] LastBitIdx = 5'd31;

  // default depth of the token queue between front and back
  localparam int unsigned QueueDepthDef = 2;

  typedef enum logic [1:0] {
    KIND_NEW    = 2'd0,
    KIND_REPEAT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_ARMED = 1'b1
  } dec_state_e;

  // scaled window bounds: 256*t must lie in [lo, hi]
  typedef struct packed {
    logic [24:0] hi;
    logic [23:0] lo;
  } window_t;

  typedef struct packed {
    window_t hdr_mark;
    window_t hdr_space;
    window_t bit_mark;
    window_t zero_space;
    window_t one_space;
  } bounds_t;

  // classified item handed from front to back
  typedef struct packed {
    logic op;
    logic hdr_ok;
    logic mark_ok;
    logic zero_ok;
    logic one_ok;
  } token_t;

  function automatic window_t calc_window(logic [15:0] nominal, logic [7:0] tol);
    logic [8:0]  sum;
    logic [8:0]  diff;
    logic [24:0] hi_prod;
    logic [24:0] lo_prod;
    window_t     w;
    sum     = 9'd256 + {1'b0, tol};
    diff    = 9'd256 - {1'b0, tol};
    hi_prod = 25'(nominal) * 25'(sum);
    lo_prod = 25'(nominal) * 25'(diff);
    w.hi    = hi_prod;
    w.lo    = lo_prod[23:0];
    return w;
  endfunction

  function automatic logic in_window(logic [15:0] t, window_t w);
    logic [23:0] scaled;
    scaled = {t, 8'h00};
    return ({1'b0, scaled} <= w.hi) && (scaled >= w.lo);
  endfunction

endpackage

// ----- design/nirfd_cfg_regs.sv -----
`timescale 1ns / 1ps
// apb register file for the timing set-up, plus registered window bounds
// depends on nirfd_pkg

module nirfd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nirfd_pkg::RegAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output nirfd_pkg::bounds_t            bounds_o,
  output logic                          extended_o
);

  logic [15:0] hdr_mark_q, hdr_space_q, bit_mark_q, zero_space_q, one_space_q;
  logic [7:0]  tol_q;
  logic        ext_q;
  logic        wr_en;
  logic [2:0]  reg_idx;
  nirfd_pkg::bounds_t bounds_d, bounds_q, bounds_rst;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_mark_q   <= nirfd_pkg::RstHdrMark;
      hdr_space_q  <= nirfd_pkg::RstHdrSpace;
      bit_mark_q   <= nirfd_pkg::RstBitMark;
      zero_space_q <= nirfd_pkg::RstZeroSpace;
      one_space_q  <= nirfd_pkg::RstOneSpace;
      tol_q        <= nirfd_pkg::RstTolerance;
      ext_q        <= nirfd_pkg::RstExtended;
    end else if (wr_en) begin
      case (reg_idx)
        nirfd_pkg::REG_HDR_MARK:   hdr_mark_q   <= pwdata[15:0];
        nirfd_pkg::REG_HDR_SPACE:  hdr_space_q  <= pwdata[15:0];
        nirfd_pkg::REG_BIT_MARK:   bit_mark_q   <= pwdata[15:0];
        nirfd_pkg::REG_ZERO_SPACE: zero_space_q <= pwdata[15:0];
        nirfd_pkg::REG_ONE_SPACE:  one_space_q  <= pwdata[15:0];
        nirfd_pkg::REG_TOLERANCE:  tol_q        <= pwdata[7:0];
        nirfd_pkg::REG_EXTENDED:   ext_q        <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    case (reg_idx)
      nirfd_pkg::REG_HDR_MARK:   prdata = {16'h0, hdr_mark_q};
      nirfd_pkg::REG_HDR_SPACE:  prdata = {16'h0, hdr_space_q};
      nirfd_pkg::REG_BIT_MARK:   prdata = {16'h0, bit_mark_q};
      nirfd_pkg::REG_ZERO_SPACE: prdata = {16'h0, zero_space_q};
      nirfd_pkg::REG_ONE_SPACE:  prdata = {16'h0, one_space_q};
      nirfd_pkg::REG_TOLERANCE:  prdata = {24'h0, tol_q};
      nirfd_pkg::REG_EXTENDED:   prdata = {31'h0, ext_q};
      default:                   prdata = 32'h0;
    endcase
  end

  // window bounds, two multiplies each, registered
  always_comb begin
    bounds_d.hdr_mark   = nirfd_pkg::calc_window(hdr_mark_q, tol_q);
    bounds_d.hdr_space  = nirfd_pkg::calc_window(hdr_space_q, tol_q);
    bounds_d.bit_mark   = nirfd_pkg::calc_window(bit_mark_q, tol_q);
    bounds_d.zero_space = nirfd_pkg::calc_window(zero_space_q, tol_q);
    bounds_d.one_space  = nirfd_pkg::calc_window(one_space_q, tol_q);
  end

  always_comb begin
    bounds_rst.hdr_mark   = nirfd_pkg::calc_window(nirfd_pkg::RstHdrMark,
                                                   nirfd_pkg::RstTolerance);
    bounds_rst.hdr_space  = nirfd_pkg::calc_window(nirfd_pkg::RstHdrSpace,
                                                   nirfd_pkg::RstTolerance);
    bounds_rst.bit_mark   = nirfd_pkg::calc_window(nirfd_pkg::RstBitMark,
                                                   nirfd_pkg::RstTolerance);
    bounds_rst.zero_space = nirfd_pkg::calc_window(nirfd_pkg::RstZeroSpace,
                                                   nirfd_pkg::RstTolerance);
    bounds_rst.one_space  = nirfd_pkg::calc_window(nirfd_pkg::RstOneSpace,
                                                   nirfd_pkg::RstTolerance);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q <= bounds_rst;
    end else begin
      bounds_q <= bounds_d;
    end
  end

  assign bounds_o   = bounds_q;
  assign extended_o = ext_q;

endmodule

// ----- design/nirfd_front.sv -----
`timescale 1ns / 1ps
// front end: takes input transactions and classifies their timings into tokens
// depends on nirfd_pkg

module nirfd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [31:0]        s_axis_tdata_i,
  input  logic               s_axis_tuser_i,
  input  nirfd_pkg::bounds_t bounds_i,
  output logic               tok_valid_o,
  input  logic               tok_ready_i,
  output nirfd_pkg::token_t  tok_o
);

  logic        in_valid_q;
  logic        in_op_q;
  logic [15:0] mark_q;
  logic [15:0] space_q;
  logic        take;

  // input stage advances when empty or when its token leaves
  assign s_axis_tready_o = !in_valid_q || tok_ready_i;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_op_q <= s_axis_tuser_i;
      mark_q  <= s_axis_tdata_i[15:0];
      space_q <= s_axis_tdata_i[31:16];
    end
  end

  // window compares against the registered bounds
  always_comb begin
    tok_o.op      = in_op_q;
    tok_o.hdr_ok  = nirfd_pkg::in_window(mark_q, bounds_i.hdr_mark) &&
                    nirfd_pkg::in_window(space_q, bounds_i.hdr_space);
    tok_o.mark_ok = nirfd_pkg::in_window(mark_q, bounds_i.bit_mark);
    tok_o.zero_ok = nirfd_pkg::in_window(space_q, bounds_i.zero_space);
    tok_o.one_ok  = nirfd_pkg::in_window(space_q, bounds_i.one_space);
  end

  assign tok_valid_o = in_valid_q;

endmodule

// ----- design/nirfd_queue.sv -----
`timescale 1ns / 1ps
// small token queue between the classifier and the decoder
// depends on nirfd_pkg

module nirfd_queue #(
  parameter int unsigned Depth = nirfd_pkg::QueueDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  nirfd_pkg::token_t push_tok_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output nirfd_pkg::token_t pop_tok_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  nirfd_pkg::token_t slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_tok_o    = slot_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

// ----- design/nirfd_back.sv -----
`timescale 1ns / 1ps
// back end: frame state machine, bit shifter, byte check and output register
// depends on nirfd_pkg

module nirfd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tok_valid_i,
  output logic              tok_ready_o,
  input  nirfd_pkg::token_t tok_i,
  input  logic              extended_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [23:0]       m_axis_tdata_o,
  output logic [1:0]        m_axis_tuser_o
);

  nirfd_pkg::dec_state_e state_q, state_d;
  logic [4:0]  bit_count_q, bit_count_d;
  logic [31:0] shift_q, shift_d, word;
  logic [15:0] last_addr_q, last_addr_d;
  logic [7:0]  last_cmd_q, last_cmd_d;
  logic        pop, bit_val, bit_good, frame_end, pair_bad;
  logic        cmd_ok, addr_ok, frame_ok;
  logic [15:0] frame_addr;
  logic        emit;
  nirfd_pkg::kind_e emit_kind;
  logic [15:0] emit_addr;
  logic [7:0]  emit_cmd;
  logic        out_valid_q, out_valid_d;
  nirfd_pkg::kind_e out_kind_q;
  logic [15:0] out_addr_q;
  logic [7:0]  out_cmd_q;

  assign tok_ready_o = !out_valid_q || m_axis_tready_i;
  assign pop         = tok_valid_i && tok_ready_o;

  // bit decode, zero window wins on overlap
  assign bit_val   = !tok_i.zero_ok;
  assign bit_good  = tok_i.zero_ok || tok_i.one_ok;
  assign pair_bad  = !tok_i.mark_ok || !bit_good;
  assign frame_end = (bit_count_q == nirfd_pkg::LastBitIdx);

  always_comb begin
    word              = shift_q;
    word[bit_count_q] = bit_val;
  end

  // inverted byte checks
  assign cmd_ok     = (~word[23:16] == word[31:24]);
  assign addr_ok    = (~word[7:0] == word[15:8]);
  assign frame_ok   = extended_i ? cmd_ok : (cmd_ok && addr_ok);
  assign frame_addr = extended_i ? word[15:0] : {8'h00, word[7:0]};

  // next state
  always_comb begin
    state_d = state_q;
    if (pop) begin
      if (tok_i.op) begin
        state_d = nirfd_pkg::ST_IDLE;
      end else begin
        case (state_q)
          nirfd_pkg::ST_IDLE: begin
            if (tok_i.hdr_ok) state_d = nirfd_pkg::ST_ARMED;
          end
          nirfd_pkg::ST_ARMED: begin
            if (pair_bad || frame_end) state_d = nirfd_pkg::ST_IDLE;
          end
          default: state_d = nirfd_pkg::ST_IDLE;
        endcase
      end
    end
  end

  // datapath and result selection
  always_comb begin
    bit_count_d = bit_count_q;
    shift_d     = shift_q;
    last_addr_d = last_addr_q;
    last_cmd_d  = last_cmd_q;
    emit        = 1'b0;
    emit_kind   = nirfd_pkg::KIND_NEW;
    emit_addr   = '0;
    emit_cmd    = '0;
    if (pop) begin
      if (tok_i.op) begin
        bit_count_d = '0;
        shift_d     = '0;
        if (state_q == nirfd_pkg::ST_ARMED) begin
          emit      = 1'b1;
          emit_kind = nirfd_pkg::KIND_REPEAT;
          emit_addr = last_addr_q;
          emit_cmd  = last_cmd_q;
        end
      end else if (state_q == nirfd_pkg::ST_ARMED) begin
        if (pair_bad) begin
          bit_count_d = '0;
          shift_d     = '0;
          emit        = 1'b1;
          emit_kind   = nirfd_pkg::KIND_ERROR;
        end else if (!frame_end) begin
          bit_count_d = bit_count_q + 1'b1;
          shift_d     = word;
        end else begin
          bit_count_d = '0;
          shift_d     = '0;
          emit        = 1'b1;
          if (frame_ok) begin
            emit_kind   = nirfd_pkg::KIND_NEW;
            emit_addr   = frame_addr;
            emit_cmd    = word[23:16];
            last_addr_d = frame_addr;
            last_cmd_d  = word[23:16];
          end else begin
            emit_kind = nirfd_pkg::KIND_ERROR;
          end
        end
      end
    end
  end

  assign out_valid_d = emit || (out_valid_q && !m_axis_tready_i);

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nirfd_pkg::ST_IDLE;
      bit_count_q <= '0;
      shift_q     <= '0;
      last_addr_q <= '0;
      last_cmd_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_count_q <= bit_count_d;
      shift_q     <= shift_d;
      last_addr_q <= last_addr_d;
      last_cmd_q  <= last_cmd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q <= emit_kind;
      out_addr_q <= emit_addr;
      out_cmd_q  <= emit_cmd;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_cmd_q, out_addr_q};
  assign m_axis_tuser_o  = out_kind_q;

endmodule

// ----- design/nec_ir_frame_decoder.sv -----
`timescale 1ns / 1ps
// top level of the nec ir frame decoder: registers, classifier, queue, decoder
// depends on nirfd_pkg, nirfd_cfg_regs, nirfd_front, nirfd_queue, nirfd_back

// Takes one mark/space pair or timeout per clock while the input is ready and
// gives at most one result per item: a new frame, a repeat of the last good
// frame on a timeout while armed, or an error. Throughput is one item per cycle
// unless the output stalls; an item's result passes the input register and window
// compares, then the token queue, then the decoder with its output register, and
// waits there while the output stalls.
// The window bounds are recomputed from the timing registers in the cycle after
// a write, so configure only while the block is idle.

module nec_ir_frame_decoder #(
  parameter int unsigned QueueDepth = nirfd_pkg::QueueDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // apb configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nirfd_pkg::RegAddrW-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // input stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [31:0]                    s_axis_tdata_i,  // mark_time, space_time
  input  logic                           s_axis_tuser_i,  // op
  // result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [23:0]                    m_axis_tdata_o,  // address, command
  output logic [1:0]                     m_axis_tuser_o   // kind
);

  nirfd_pkg::bounds_t bounds;
  logic               extended;
  logic               front_valid, front_ready;
  nirfd_pkg::token_t  front_tok;
  logic               tok_valid, tok_ready;
  nirfd_pkg::token_t  tok;
  logic               tok_pop;

  nirfd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .bounds_o   (bounds),
    .extended_o (extended)
  );

  nirfd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .bounds_i        (bounds),
    .tok_valid_o     (front_valid),
    .tok_ready_i     (front_ready),
    .tok_o           (front_tok)
  );

  nirfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_tok_i   (front_tok),
    .pop_valid_o  (tok_valid),
    .pop_ready_i  (tok_ready),
    .pop_tok_o    (tok)
  );

  nirfd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tok_valid_i     (tok_valid),
    .tok_ready_o     (tok_ready),
    .tok_i           (tok),
    .extended_i      (extended),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  assign tok_pop = tok_valid && tok_ready;

  // a fresh result only follows a token taken by the decoder
  a_result_from_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(tok_pop))
    else $error("result appeared without a decoded token");

  // input side only stalls while the classifier holds an item
  a_stall_has_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> front_valid)
    else $error("input stalled with empty classifier stage");

  // normal mode frames carry an 8-bit address
  a_normal_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !extended && (m_axis_tuser_o == nirfd_pkg::KIND_NEW))
      |-> (m_axis_tdata_o[15:8] == 8'h00))
    else $error("normal mode frame with nonzero upper address byte");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the nec ir frame decoder: drives pulse timings and
// timeouts, predicts every result and compares the output stream against it
// depends on nirfd_pkg and nec_ir_frame_decoder

module testbench;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 85;
  localparam int unsigned MaxReports = 100;

  typedef struct packed {
    nirfd_pkg::kind_e kind;
    logic [15:0]      address;
    logic [7:0]       command;
  } ir_result_t;

  // decoder state mirror and queue of results still to come out
  class ir_decode_board;
    logic [15:0] hdr_mark;
    logic [15:0] hdr_space;
    logic [15:0] bit_mark;
    logic [15:0] zero_space;
    logic [15:0] one_space;
    logic [7:0]  tol;
    logic        ext;
    logic        armed;
    logic [4:0]  nbits;
    logic [31:0] word;
    logic [15:0] last_address;
    logic [7:0]  last_command;
    ir_result_t  due_results[$];
    int unsigned errors;

    function new();
      hdr_mark     = nirfd_pkg::RstHdrMark;
      hdr_space    = nirfd_pkg::RstHdrSpace;
      bit_mark     = nirfd_pkg::RstBitMark;
      zero_space   = nirfd_pkg::RstZeroSpace;
      one_space    = nirfd_pkg::RstOneSpace;
      tol          = nirfd_pkg::RstTolerance;
      ext          = nirfd_pkg::RstExtended;
      last_address = '0;
      last_command = '0;
      errors       = 0;
      clear_frame();
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        nirfd_pkg::REG_HDR_MARK:   hdr_mark   = value[15:0];
        nirfd_pkg::REG_HDR_SPACE:  hdr_space  = value[15:0];
        nirfd_pkg::REG_BIT_MARK:   bit_mark   = value[15:0];
        nirfd_pkg::REG_ZERO_SPACE: zero_space = value[15:0];
        nirfd_pkg::REG_ONE_SPACE:  one_space  = value[15:0];
        nirfd_pkg::REG_TOLERANCE:  tol        = value[7:0];
        nirfd_pkg::REG_EXTENDED:   ext        = value[0];
        default: ;
      endcase
    endfunction

    // exact integer tolerance window
    function bit fits(logic [15:0] t, logic [15:0] nominal);
      int unsigned scaled;
      int unsigned hi;
      int unsigned lo;
      scaled = 32'(t) << 8;
      hi     = 32'(nominal) * (32'd256 + 32'(tol));
      lo     = 32'(nominal) * (32'd256 - 32'(tol));
      return (scaled <= hi) && (scaled >= lo);
    endfunction

    function void clear_frame();
      armed = 1'b0;
      nbits = '0;
      word  = '0;
    endfunction

    function void expect_result(nirfd_pkg::kind_e kind, logic [15:0] address,
                                logic [7:0] command);
      ir_result_t r;
      r.kind    = kind;
      r.address = address;
      r.command = command;
      due_results.push_back(r);
    endfunction

    // lsb-first shift, byte checks after the last bit
    function void shift_bit(logic b);
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic [7:0]  b3;
      logic        ok;
      logic [15:0] address;
      word[nbits] = word[nbits] | b;
      if (nbits != nirfd_pkg::LastBitIdx) begin
        nbits = nbits + 5'd1;
        return;
      end
      b0 = word[7:0];
      b1 = word[15:8];
      b2 = word[23:16];
      b3 = word[31:24];
      ok = ((~b2) == b3);
      if (ext) begin
        address = {b1, b0};
      end else begin
        ok      = ok && ((~b0) == b1);
        address = {8'h00, b0};
      end
      clear_frame();
      if (!ok) begin
        expect_result(nirfd_pkg::KIND_ERROR, '0, '0);
      end else begin
        last_address = address;
        last_command = b2;
        expect_result(nirfd_pkg::KIND_NEW, address, b2);
      end
    endfunction

    // one accepted input transaction
    function void take_pair(logic op, logic [15:0] mark, logic [15:0] space);
      if (op) begin
        if (armed) expect_result(nirfd_pkg::KIND_REPEAT, last_address, last_command);
        clear_frame();
      end else if (!armed) begin
        if (fits(mark, hdr_mark) && fits(space, hdr_space)) armed = 1'b1;
      end else if (!fits(mark, bit_mark)) begin
        clear_frame();
        expect_result(nirfd_pkg::KIND_ERROR, '0, '0);
      end else if (fits(space, zero_space)) begin
        shift_bit(1'b0);
      end else if (fits(space, one_space)) begin
        shift_bit(1'b1);
      end else begin
        clear_frame();
        expect_result(nirfd_pkg::KIND_ERROR, '0, '0);
      end
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      errors++;
      if (errors <= MaxReports)
        $display("%0t: %s expected %h actual %h", $time, field, want, got);
    endfunction

    // one accepted output transaction
    function void match_output(logic [1:0] kind, logic [15:0] address, logic [7:0] command);
      ir_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: result with none expected: kind %0d address %h command %h",
                   $time, kind, address, command);
        return;
      end
      want = due_results.pop_front();
      if (kind !== want.kind) report("kind", want.kind, kind);
      if (address !== want.address) report("address", want.address, address);
      if (command !== want.command) report("command", want.command, command);
    endfunction
  endclass

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           psel            = 1'b0;
  logic                           penable         = 1'b0;
  logic                           pwrite          = 1'b0;
  logic [nirfd_pkg::RegAddrW-1:0] paddr           = '0;
  logic [31:0]                    pwdata          = '0;
  logic [31:0]                    prdata;
  logic                           pready;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [31:0]                    s_axis_tdata_i  = '0;  // mark_time, space_time
  logic                           s_axis_tuser_i  = 1'b0;  // op
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [23:0]                    m_axis_tdata_o;  // address, command
  logic [1:0]                     m_axis_tuser_o;  // kind

  bit             src_quiet  = 1'b0;
  bit             sink_quiet = 1'b0;
  int unsigned    ready_hold = 0;
  ir_decode_board board      = new();

  nec_ir_frame_decoder i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // output side: check each transaction and stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      board.match_output(m_axis_tuser_o, m_axis_tdata_o[15:0], m_axis_tdata_o[23:16]);
    if (ready_hold == 0) begin
      if (sink_quiet || $urandom_range(0, 99) < 65) begin
        m_axis_tready_i <= 1'b1;
        ready_hold = sink_quiet ? 1 : idle_len(1'b0) + 1;
      end else begin
        m_axis_tready_i <= 1'b0;
        ready_hold = idle_len(1'b0) + 1;
      end
    end
    ready_hold = ready_hold - 1;
  end

  // range of times that match a nominal value at the current tolerance
  function automatic void window_span(logic [15:0] nominal, output int unsigned lo,
                                      output int unsigned hi);
    lo = (32'(nominal) * (32'd256 - 32'(board.tol)) + 32'd255) / 32'd256;
    hi = (32'(nominal) * (32'd256 + 32'(board.tol))) / 32'd256;
    if (hi > 32'd65535) hi = 32'd65535;
  endfunction

  function automatic logic [15:0] near(logic [15:0] nominal);
    int unsigned lo;
    int unsigned hi;
    window_span(nominal, lo, hi);
    return 16'($urandom_range(hi, lo));
  endfunction

  function automatic logic [15:0] away(logic [15:0] nominal);
    int unsigned lo;
    int unsigned hi;
    window_span(nominal, lo, hi);
    if (lo > 0 && (hi >= 65535 || $urandom_range(0, 1) == 1))
      return 16'($urandom_range(lo - 1, 0));
    if (hi < 65535) return 16'($urandom_range(65535, hi + 1));
    return 16'($urandom);
  endfunction

  // one input transaction after a random gap
  task automatic send(logic op, logic [15:0] mark, logic [15:0] space);
    int unsigned gap;
    gap = idle_len(src_quiet);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {space, mark};
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.take_pair(op, mark, space);
  endtask

  // apb write: setup then access, select is dropped by the caller
  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    logic [31:0] data;
    data = {16'($urandom), value};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_reg(idx, data);
  endtask

  // wait for every result, then for items that give none to pass through
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apply_cfg(logic [15:0] hm, logic [15:0] hs, logic [15:0] bm,
                           logic [15:0] zs, logic [15:0] os, logic [7:0] tol,
                           logic ext);
    drain();
    write_reg(nirfd_pkg::REG_HDR_MARK, hm);
    write_reg(nirfd_pkg::REG_HDR_SPACE, hs);
    write_reg(nirfd_pkg::REG_BIT_MARK, bm);
    write_reg(nirfd_pkg::REG_ZERO_SPACE, zs);
    write_reg(nirfd_pkg::REG_ONE_SPACE, os);
    write_reg(nirfd_pkg::REG_TOLERANCE, {8'($urandom), tol});
    write_reg(nirfd_pkg::REG_EXTENDED, {15'($urandom), ext});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    repeat (2) @(posedge clk_i);
  endtask

  // one frame attempt: good, corrupted, cut short, timed out, or plain noise
  task automatic run_frame(output int unsigned sent);
    int unsigned mode;
    int unsigned cut;
    int unsigned n;
    logic [15:0] address;
    logic [7:0]  command;
    logic [31:0] word;
    mode    = $urandom_range(0, 99);
    address = 16'($urandom);
    command = 8'($urandom);
    cut     = $urandom_range(0, 31);
    sent    = 0;
    if (board.ext) word = {~command, command, address};
    else word = {~command, command, ~address[7:0], address[7:0]};
    if (mode >= 88) begin
      n = $urandom_range(1, 4);
      repeat (n) send($urandom_range(0, 3) == 0, 16'($urandom), 16'($urandom));
      return;
    end
    if (mode >= 50 && mode < 60) word = word ^ (32'h1 << $urandom_range(0, 31));
    else if (mode >= 60 && mode < 66) word = $urandom;
    else if (mode >= 76 && $urandom_range(0, 1) == 1) cut = 0;  // repeat code
    send(1'b0, near(board.hdr_mark), near(board.hdr_space));
    sent = 1;
    for (int i = 0; i < 32; i++) begin
      if (mode >= 66 && mode < 76 && i == cut) begin
        if ($urandom_range(0, 1) == 1)
          send(1'b0, away(board.bit_mark), near(board.zero_space));
        else
          send(1'b0, near(board.bit_mark), away(board.one_space));
        sent++;
        return;
      end
      if (mode >= 76 && i == cut) begin
        send(1'b1, 16'($urandom), 16'($urandom));
        sent++;
        return;
      end
      send(1'b0, near(board.bit_mark), near(word[i] ? board.one_space : board.zero_space));
      sent++;
    end
  endtask

  task automatic run_phase();
    int unsigned count;
    int unsigned sent;
    count = 0;
    while (count < PhaseItems) begin
      src_quiet  = ($urandom_range(0, 7) == 0);
      sink_quiet = ($urandom_range(0, 7) == 0);
      run_frame(sent);
      count += sent;
    end
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
  endtask

  // short cases at reset timings
  task automatic run_directed();
    send(1'b1, 16'hffff, 16'hffff);  // timeout while idle
    send(1'b0, 16'h0000, 16'h0000);  // idle pair that is no header
    send(1'b0, 16'hffff, 16'hffff);
    send(1'b0, nirfd_pkg::RstHdrMark, nirfd_pkg::RstHdrSpace);
    send(1'b1, 16'h0000, 16'h0000);  // repeat of the never-set frame
    send(1'b0, nirfd_pkg::RstHdrMark, nirfd_pkg::RstHdrSpace);
    send(1'b0, 16'hffff, nirfd_pkg::RstZeroSpace);  // bad mark
    send(1'b0, nirfd_pkg::RstHdrMark, nirfd_pkg::RstHdrSpace);
    send(1'b0, nirfd_pkg::RstBitMark, 16'hffff);  // bad space
    send(1'b0, nirfd_pkg::RstHdrMark, nirfd_pkg::RstHdrSpace);
    send(1'b0, 16'h0000, 16'h0000);  // mark far too short
    send(1'b0, nirfd_pkg::RstHdrMark, nirfd_pkg::RstHdrSpace);
    send(1'b0, nirfd_pkg::RstBitMark, nirfd_pkg::RstOneSpace);
    send(1'b0, nirfd_pkg::RstBitMark, nirfd_pkg::RstZeroSpace);
    send(1'b1, 16'hffff, 16'h0000);  // timeout mid-frame
    send(1'b0, nirfd_pkg::RstHdrMark, nirfd_pkg::RstHdrSpace);
    // header timing where a bit is due
    send(1'b0, nirfd_pkg::RstHdrMark, nirfd_pkg::RstHdrSpace);
    send(1'b0, 16'd11250, 16'd3375);  // window edges
    send(1'b1, 16'h5555, 16'haaaa);
    send(1'b0, 16'd11251, 16'd4500);  // just past the upper edge
    send(1'b0, 16'd9000, 16'd3374);  // just under the lower edge
  endtask

  // run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("nec_ir_frame_decoder: mismatch");
    $finish;
  end

  // reset, then directed cases and random phases over several settings
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_phase();
    apply_cfg(nirfd_pkg::RstHdrMark, nirfd_pkg::RstHdrSpace, nirfd_pkg::RstBitMark,
              nirfd_pkg::RstZeroSpace, nirfd_pkg::RstOneSpace,
              nirfd_pkg::RstTolerance, 1'b1);
    run_phase();
    // exact match only
    apply_cfg(16'd9000, 16'd4500, 16'd560, 16'd560, 16'd1690, 8'd0, 1'b0);
    run_phase();
    // widest tolerance, zero and one windows overlap
    apply_cfg(16'd9000, 16'd4500, 16'd560, 16'd1000, 16'd1200, 8'd255, 1'b1);
    run_phase();
    apply_cfg(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 8'($urandom), 1'($urandom));
    run_phase();
    // timing extremes
    apply_cfg(16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 8'd255, 1'b0);
    run_phase();
    drain();
    if (board.errors == 0) begin
      $display("nec_ir_frame_decoder: match");
    end else begin
      $display("nec_ir_frame_decoder: mismatch");
    end
    $finish;
  end

endmodule
